### rtl/xtwc_pkg.sv
`default_nettype none
package xtwc_pkg;

  localparam int NUM_WAYS  = 2;
  localparam int TAG_W     = 11;
  localparam int TAG_ENT_W = TAG_W + 1;
  localparam int LINE_W    = 64;

  localparam logic [1:0] FUNC_BYTE = 2'd0;
  localparam logic [1:0] FUNC_HALF = 2'd1;
  localparam logic [1:0] FUNC_WORD = 2'd2;
  localparam logic [1:0] FUNC_WR   = 2'd3;

  localparam logic [3:0] MODE_ALLOC    = 4'd0;
  localparam logic [3:0] MODE_NOALLOC  = 4'd1;
  localparam logic [3:0] MODE_FORCE    = 4'd2;
  localparam logic [3:0] MODE_BYPASS   = 4'd3;
  localparam logic [3:0] MODE_REGS     = 4'd4;
  localparam logic [3:0] MODE_STORE    = 4'd5;

  localparam logic [13:0] REG_CTRL   = 14'h0000;
  localparam logic [13:0] REG_STAT   = 14'h0008;
  localparam logic [13:0] REG_HITS   = 14'h000c;
  localparam logic [13:0] REG_ACCESS = 14'h0010;

  localparam logic [31:0] CTRL_VALUE = 32'h0000_000b;
  localparam logic [31:0] STAT_VALUE = 32'h0000_0003;

  typedef struct packed {
    logic [1:0]        func;
    logic [27:0]       addr;
    logic [LINE_W-1:0] flash_line;
    logic              victim_pick;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        was_hit;
  } rsp_t;

  typedef struct packed {
    logic take;
    logic clr;
    logic quo;
    logic rem;
    logic direct;
    logic look;
    logic bget;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_cache;
    logic is_store;
    logic last_byte;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

### rtl/xtwc_ctrl.sv
`default_nettype none
module xtwc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire xtwc_pkg::sts_t sts,
  output xtwc_pkg::cmd_t     cmd
);
  import xtwc_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_DEC   = 8'b0000_0100,
    S_REM   = 8'b0000_1000,
    S_RD    = 8'b0001_0000,
    S_LOOK  = 8'b0010_0000,
    S_BGET  = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        if (in_valid) state_nxt = S_DEC;
      end
      S_DEC: begin
        cmd.quo = 1'b1;
        if (sts.is_cache || sts.is_store) begin
          state_nxt = S_REM;
        end else begin
          cmd.direct = 1'b1;
          state_nxt  = S_FIN;
        end
      end
      S_REM: begin
        cmd.rem   = 1'b1;
        state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = sts.is_store ? S_BGET : S_LOOK;
      end
      S_LOOK: begin
        cmd.look  = 1'b1;
        state_nxt = S_FIN;
      end
      S_BGET: begin
        cmd.bget  = 1'b1;
        state_nxt = sts.last_byte ? S_FIN : S_RD;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

### rtl/xtwc_dp.sv
`default_nettype none
module xtwc_dp #(
  parameter int NUM_SETS = 1024
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire xtwc_pkg::req_t  in_data,
  input  wire xtwc_pkg::cmd_t  cmd,
  output xtwc_pkg::sts_t       sts,
  output xtwc_pkg::rsp_t       out_data,
  output logic                 out_valid,
  input  wire logic            out_ready
);
  import xtwc_pkg::*;

  localparam int SW        = $clog2(NUM_SETS);
  localparam int MOD_SHIFT = 20;
  localparam int MOD_MULT  = (1 << MOD_SHIFT) / NUM_SETS;
  localparam int ROW_TAG_W = NUM_WAYS * TAG_ENT_W;
  localparam int ROW_LN_W  = NUM_WAYS * LINE_W;
  localparam logic [SW-1:0] LAST_SET = SW'(NUM_SETS - 1);

  logic [ROW_TAG_W-1:0] tag_mem  [NUM_SETS];
  logic [ROW_LN_W-1:0]  line_mem [NUM_SETS];

  req_t                 req_r;
  logic [9:0]           q_r;
  logic [SW-1:0]        set_r, set_nxt;
  logic [3:0]           off_r;
  logic [13:0]          j_r;
  logic [1:0]           cnt_r;
  logic [SW-1:0]        clr_r;
  logic [ROW_TAG_W-1:0] rd_tag_r;
  logic [ROW_LN_W-1:0]  rd_line_r;
  rsp_t                 res_r, out_r;
  logic                 out_valid_r;
  logic [31:0]          hit_cnt_r, acc_cnt_r;

  logic [3:0]           mode;
  logic                 is_rd;
  logic [9:0]           raw;
  logic [29:0]          prod;
  logic [9:0]           qd, r0;
  logic [12:0]          r13, r_fix;
  logic [TAG_W-1:0]     tag;
  logic                 v0, v1, hit0, hit1, hit, hway, victim, fill;
  logic [LINE_W-1:0]    use_line;
  logic [ROW_TAG_W-1:0] wtag;
  logic [ROW_LN_W-1:0]  wline;
  logic [SW-1:0]        wa;
  logic                 mem_we;
  logic [31:0]          direct_data, reg_data;
  logic [13:0]          j_nxt;

  function automatic logic [31:0] from_line(input logic [LINE_W-1:0] line,
                                            input logic [2:0] off,
                                            input logic [1:0] func);
    logic [2*LINE_W-1:0] dbl;
    logic [LINE_W-1:0]   rot;
    logic [31:0]         v;
    dbl = {line, line};
    rot = dbl[{off, 3'b000} +: LINE_W];
    v   = rot[31:0];
    case (func)
      FUNC_BYTE: v = v & 32'h0000_00ff;
      FUNC_HALF: v = v & 32'h0000_ffff;
      default:   v = v;
    endcase
    return v;
  endfunction

  assign mode  = req_r.addr[27:24];
  assign is_rd = req_r.func != FUNC_WR;
  assign raw   = (mode == MODE_STORE) ? req_r.addr[13:4] : req_r.addr[12:3];
  assign prod  = 30'(raw) * 30'(MOD_MULT);

  // set = raw mod NUM_SETS via reciprocal, then one correction step
  assign qd    = 10'(q_r * NUM_SETS);
  assign r0    = raw - qd;
  assign r13   = {3'b000, r0};
  assign r_fix = (r13 >= 13'(NUM_SETS)) ? r13 - 13'(NUM_SETS) : r13;

  assign tag    = req_r.addr[23:13];
  assign v0     = rd_tag_r[TAG_ENT_W-1];
  assign v1     = rd_tag_r[ROW_TAG_W-1];
  assign hit0   = v0 && (rd_tag_r[TAG_W-1:0] == tag);
  assign hit1   = v1 && (rd_tag_r[TAG_ENT_W +: TAG_W] == tag);
  assign hit    = (mode == MODE_ALLOC || mode == MODE_NOALLOC) && (hit0 || hit1);
  assign hway   = !hit0;
  assign victim = !v0 ? 1'b0 : (!v1 ? 1'b1 : req_r.victim_pick);
  assign fill   = (mode == MODE_ALLOC && !hit) || mode == MODE_FORCE;

  always_comb begin
    if (hit) use_line = hway ? rd_line_r[LINE_W +: LINE_W] : rd_line_r[LINE_W-1:0];
    else     use_line = req_r.flash_line;
  end

  always_comb begin
    wtag  = rd_tag_r;
    wline = rd_line_r;
    if (victim) begin
      wtag[TAG_ENT_W +: TAG_ENT_W] = {1'b1, tag};
      wline[LINE_W +: LINE_W]      = req_r.flash_line;
    end else begin
      wtag[TAG_ENT_W-1:0] = {1'b1, tag};
      wline[LINE_W-1:0]   = req_r.flash_line;
    end
    if (cmd.clr) begin
      wtag  = '0;
      wline = '0;
    end
  end

  assign wa     = cmd.clr ? clr_r : set_r;
  assign mem_we = cmd.clr || (cmd.look && fill);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[wa]  <= wtag;
      line_mem[wa] <= wline;
    end
    rd_tag_r  <= tag_mem[set_r];
    rd_line_r <= line_mem[set_r];
  end

  always_comb begin
    case (req_r.addr[13:0])
      REG_CTRL:   reg_data = CTRL_VALUE;
      REG_STAT:   reg_data = STAT_VALUE;
      REG_HITS:   reg_data = hit_cnt_r;
      REG_ACCESS: reg_data = acc_cnt_r;
      default:    reg_data = '0;
    endcase
    direct_data = '0;
    if (is_rd) begin
      case (mode)
        MODE_BYPASS: direct_data = from_line(req_r.flash_line, req_r.addr[2:0], req_r.func);
        MODE_REGS:   direct_data = reg_data;
        default:     direct_data = '0;
      endcase
    end
  end

  // walk the store byte by byte; the raw index wraps at the window end first
  assign j_nxt = j_r + 14'd1;
  always_comb begin
    set_nxt = set_r;
    if (cmd.rem) begin
      set_nxt = SW'(r_fix);
    end else if (cmd.bget) begin
      if (j_nxt == '0)           set_nxt = '0;
      else if (off_r == 4'hf)    set_nxt = (set_r == LAST_SET) ? '0 : set_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) req_r <= in_data;
    if (cmd.quo)  q_r   <= prod[MOD_SHIFT +: 10];
    set_r <= set_nxt;
    if (cmd.rem) begin
      off_r <= req_r.addr[3:0];
      j_r   <= req_r.addr[13:0];
      cnt_r <= '0;
      res_r <= '0;
    end
    if (cmd.bget) begin
      res_r.read_data[{cnt_r, 3'b000} +: 8] <= rd_line_r[{off_r, 3'b000} +: 8];
      cnt_r <= cnt_r + 2'd1;
      j_r   <= j_nxt;
      off_r <= (j_nxt == '0) ? 4'h0 : off_r + 4'h1;
    end
    if (cmd.direct) begin
      res_r.read_data <= direct_data;
      res_r.was_hit   <= 1'b0;
    end
    if (cmd.look) begin
      res_r.read_data <= from_line(use_line, req_r.addr[2:0], req_r.func);
      res_r.was_hit   <= hit;
    end
    if (cmd.emit) out_r <= res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      clr_r       <= '0;
      hit_cnt_r   <= '0;
      acc_cnt_r   <= '0;
    end else begin
      if (cmd.emit)      out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cmd.clr)       clr_r <= clr_r + 1'b1;
      if (cmd.look) begin
        acc_cnt_r <= acc_cnt_r + 32'd1;
        if (hit) hit_cnt_r <= hit_cnt_r + 32'd1;
      end
    end
  end

  assign sts.clr_done  = clr_r == LAST_SET;
  assign sts.is_cache  = is_rd && (mode == MODE_ALLOC || mode == MODE_NOALLOC ||
                                   mode == MODE_FORCE);
  assign sts.is_store  = is_rd && mode == MODE_STORE;
  assign sts.last_byte = (req_r.func == FUNC_BYTE) ||
                         (req_r.func == FUNC_HALF && cnt_r == 2'd1) || (cnt_r == 2'd3);
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

### rtl/xip_two_way_cache_controller.sv
`default_nettype none
// Two-way set-associative read cache for execute-in-place flash, 8-byte lines,
// NUM_SETS sets, with bypass, register window and direct data-store modes picked
// by address bits 27:24. One item is in work at a time. A cached lookup steps through
// decode, set reduction, memory read, tag compare with result load, and a finish step
// that loads the output register; bypass, register and write items go from decode
// straight to the finish step; a data-store read does decode and set reduction, then
// one row read and one byte gather for each byte, then the finish step.
// After reset a clearing pass writes every set row of the tag and line memories
// before the first item is taken. A finished result waits in the output register; a
// second result stalls until the first is taken.
module xip_two_way_cache_controller #(
  parameter int NUM_SETS = 1024
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire xtwc_pkg::req_t in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output xtwc_pkg::rsp_t      out_data
);
  import xtwc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  xtwc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  xtwc_dp #(.NUM_SETS(NUM_SETS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule
`default_nettype wire

### rtl/xtwc_checker.sv
`default_nettype none
module xtwc_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire xtwc_pkg::rsp_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result item dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken while another is in work");

  // a fresh item cannot produce its result on the very next cycle
  a_result_not_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (!out_valid || out_ready) |=> !out_valid)
    else $error("result item appeared too early");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("ports active right after reset");

endmodule

bind xip_two_way_cache_controller xtwc_checker u_chk (.*);
`default_nettype wire
